[rtl/core/sfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, constants and item types for the Schlick Fresnel pipeline.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int IN_W       = 16;
  localparam int Q_W        = FRAC_BITS + 1;
  localparam int C_W        = FRAC_BITS + 2;
  localparam int PROD_W     = 2 * IN_W;
  localparam int DOT_W      = PROD_W + 2;
  localparam int SN_W       = 3 * IN_W;
  localparam int RN_W       = 2 * IN_W;
  localparam int SQ_W       = 2 * FRAC_BITS + 2;
  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = Q_W;
  localparam int REFL_W     = 15;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(2 ** FRAC_BITS);

  typedef struct packed {
    logic signed [IN_W-1:0] eye_x;
    logic signed [IN_W-1:0] eye_y;
    logic signed [IN_W-1:0] eye_z;
    logic signed [IN_W-1:0] norm_x;
    logic signed [IN_W-1:0] norm_y;
    logic signed [IN_W-1:0] norm_z;
    logic [IN_W-1:0]        index_from;
    logic [IN_W-1:0]        index_to;
  } hit_t;

  typedef struct packed {
    logic [REFL_W-1:0] reflectance;
    logic              internal_reflect;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/sfr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_hit_if / sfr_res_if
// Valid/ready channels for hit items and reflectance results.
// ----------------------------------------------------------------------------
interface sfr_hit_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] eye_x;
  logic signed [15:0] eye_y;
  logic signed [15:0] eye_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [15:0]        index_from;
  logic [15:0]        index_to;
  modport source (output valid, eye_x, eye_y, eye_z, norm_x, norm_y, norm_z,
                  index_from, index_to, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, norm_x, norm_y, norm_z,
                index_from, index_to, output ready);
endinterface

interface sfr_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] reflectance;
  logic        internal_reflect;
  modport source (output valid, reflectance, internal_reflect, input ready);
  modport sink (input valid, reflectance, internal_reflect, output ready);
endinterface
`default_nettype wire

[rtl/core/sfr_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_datapath
// Pipelined dot product, refraction test, two restoring dividers, square
// root and fifth power; advances as one when en is high.
// ----------------------------------------------------------------------------
module sfr_datapath (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  sfr_pkg::hit_t in_data,
  output logic          out_vld,
  output sfr_pkg::res_t out_data
);
  import sfr_pkg::*;

  typedef struct packed {
    logic signed [PROD_W-1:0] px;
    logic signed [PROD_W-1:0] py;
    logic signed [PROD_W-1:0] pz;
    logic [PROD_W-1:0]        n1sq;
    logic [PROD_W-1:0]        n2sq;
    logic [IN_W-1:0]          d;
    logic [IN_W:0]            s;
    logic                     gt;
  } st1_t;

  typedef struct packed {
    logic signed [C_W-1:0] c;
    logic [Q_W-1:0]        rest;
    logic [PROD_W-1:0]     n1sq;
    logic [PROD_W-1:0]     n2sq;
    logic [IN_W-1:0]       d;
    logic [IN_W:0]         s;
    logic                  gt;
  } st_t;

  typedef struct packed {
    logic                  gt;
    logic                  tir;
    logic                  sz;
    logic signed [C_W-1:0] c;
    logic [SN_W-1:0]       snum;
    logic [SN_W-1:0]       sden;
    logic [Q_W-1:0]        sq;
    logic [RN_W-1:0]       rnum;
    logic [RN_W-1:0]       rden;
    logic [Q_W-1:0]        rq;
  } div_t;

  typedef struct packed {
    logic                  gt;
    logic                  tir;
    logic                  sz;
    logic signed [C_W-1:0] c;
    logic [Q_W-1:0]        rq;
    logic [SQ_W-1:0]       v;
    logic [SQ_W-1:0]       root;
  } sqt_t;

  typedef struct packed {
    logic           tir;
    logic           cpos;
    logic [Q_W-1:0] x;
    logic [Q_W-1:0] xp;
    logic [Q_W-1:0] r0;
  } pw_t;

  // stage 1: products
  logic s1_vld;
  st1_t s1;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= in_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1.px   <= $signed(in_data.eye_x) * $signed(in_data.norm_x);
      s1.py   <= $signed(in_data.eye_y) * $signed(in_data.norm_y);
      s1.pz   <= $signed(in_data.eye_z) * $signed(in_data.norm_z);
      s1.n1sq <= in_data.index_from * in_data.index_from;
      s1.n2sq <= in_data.index_to * in_data.index_to;
      s1.d    <= (in_data.index_from > in_data.index_to) ?
                 in_data.index_from - in_data.index_to :
                 in_data.index_to - in_data.index_from;
      s1.s    <= {1'b0, in_data.index_from} + {1'b0, in_data.index_to};
      s1.gt   <= in_data.index_from > in_data.index_to;
    end
  end

  // stage 2: sum, rescale, clamp to -1 .. 1
  localparam logic signed [DOT_W-1:0] CMAX = DOT_W'(ONE_Q);
  logic signed [DOT_W-1:0] dot, dsh;
  logic signed [C_W-1:0]   cclamp;
  always_comb begin
    dot = DOT_W'($signed(s1.px)) + DOT_W'($signed(s1.py)) + DOT_W'($signed(s1.pz));
    dsh = dot >>> FRAC_BITS;
    if (dsh > CMAX) cclamp = C_W'(ONE_Q);
    else if (dsh < -CMAX) cclamp = -$signed(C_W'(ONE_Q));
    else cclamp = dsh[C_W-1:0];
  end

  logic s2_vld;
  st_t  s2;
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2.c    <= cclamp;
      s2.rest <= '0;
      s2.n1sq <= s1.n1sq;
      s2.n2sq <= s1.n2sq;
      s2.d    <= s1.d;
      s2.s    <= s1.s;
      s2.gt   <= s1.gt;
    end
  end

  // stage 3: 1 - cos^2
  logic signed [2*C_W-1:0] csq;
  assign csq = s2.c * s2.c;

  st_t s3_next;
  always_comb begin
    s3_next      = s2;
    s3_next.rest = ONE_Q - csq[FRAC_BITS +: Q_W];
  end

  logic s3_vld;
  st_t  s3;
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (en) s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    if (en) s3 <= s3_next;
  end

  // stage 4: divider operands
  logic s4_vld;
  div_t s4;
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (en) s4_vld <= s3_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s4.gt   <= s3.gt;
      s4.tir  <= 1'b0;
      s4.sz   <= (s3.s == '0);
      s4.c    <= s3.c;
      s4.snum <= SN_W'(s3.n1sq) * SN_W'(s3.rest);
      s4.sden <= SN_W'(s3.n2sq);
      s4.sq   <= '0;
      s4.rnum <= RN_W'({s3.d, FRAC_BITS'(0)});
      s4.rden <= RN_W'(s3.s);
      s4.rq   <= '0;
    end
  end

  // stage 5: total internal reflection when the quotient exceeds one
  logic [SN_W-1:0] tir_lim;
  assign tir_lim = (s4.sden << FRAC_BITS) + s4.sden;

  div_t dv0_next;
  always_comb begin
    dv0_next     = s4;
    dv0_next.tir = s4.gt && (s4.snum >= tir_lim);
  end

  logic dv_vld [DIV_STEPS+1];
  div_t dv     [DIV_STEPS+1];
  always_ff @(posedge clk) begin
    if (rst) dv_vld[0] <= 1'b0;
    else if (en) dv_vld[0] <= s4_vld;
  end
  always_ff @(posedge clk) begin
    if (en) dv[0] <= dv0_next;
  end

  // restoring division, one quotient bit per stage for both quotients
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [SN_W-1:0] ssh;
    logic [RN_W-1:0] rsh;
    logic            sb, rb;
    div_t            nx;
    always_comb begin
      ssh = dv[k].sden << (DIV_STEPS - 1 - k);
      rsh = dv[k].rden << (DIV_STEPS - 1 - k);
      sb  = dv[k].snum >= ssh;
      rb  = dv[k].rnum >= rsh;
      nx      = dv[k];
      nx.snum = sb ? dv[k].snum - ssh : dv[k].snum;
      nx.rnum = rb ? dv[k].rnum - rsh : dv[k].rnum;
      nx.sq   = {dv[k].sq[Q_W-2:0], sb};
      nx.rq   = {dv[k].rq[Q_W-2:0], rb};
    end
    always_ff @(posedge clk) begin
      if (rst) dv_vld[k+1] <= 1'b0;
      else if (en) dv_vld[k+1] <= dv_vld[k];
    end
    always_ff @(posedge clk) begin
      if (en) dv[k+1] <= nx;
    end
  end

  // square root of (1 - sin^2) scaled, one result bit per stage
  logic sq_vld [SQRT_STEPS+1];
  sqt_t sr     [SQRT_STEPS+1];
  always_ff @(posedge clk) begin
    if (rst) sq_vld[0] <= 1'b0;
    else if (en) sq_vld[0] <= dv_vld[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sr[0].gt   <= dv[DIV_STEPS].gt;
      sr[0].tir  <= dv[DIV_STEPS].tir;
      sr[0].sz   <= dv[DIV_STEPS].sz;
      sr[0].c    <= dv[DIV_STEPS].c;
      sr[0].rq   <= dv[DIV_STEPS].rq;
      sr[0].v    <= SQ_W'(ONE_Q - dv[DIV_STEPS].sq) << FRAC_BITS;
      sr[0].root <= '0;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    sqt_t            nx;
    always_comb begin
      trial = sr[j].root + BIT;
      nx    = sr[j];
      if (sr[j].v >= trial) begin
        nx.v    = sr[j].v - trial;
        nx.root = (sr[j].root >> 1) + BIT;
      end else begin
        nx.root = sr[j].root >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) sq_vld[j+1] <= 1'b0;
      else if (en) sq_vld[j+1] <= sq_vld[j];
    end
    always_ff @(posedge clk) begin
      if (en) sr[j+1] <= nx;
    end
  end

  // power stage 1: final cosine, x = 1 - cos, r0
  logic signed [C_W-1:0]   cfin;
  logic signed [C_W:0]     xfull;
  logic [2*Q_W-1:0]        rqsq;
  assign cfin  = (sr[SQRT_STEPS].gt && !sr[SQRT_STEPS].tir) ?
                 $signed(sr[SQRT_STEPS].root[C_W-1:0]) : sr[SQRT_STEPS].c;
  assign xfull = $signed((C_W+1)'(ONE_Q)) - (C_W+1)'(cfin);
  assign rqsq  = sr[SQRT_STEPS].rq * sr[SQRT_STEPS].rq;

  logic p1_vld, p2_vld, p3_vld, p4_vld;
  pw_t  p1, p2, p3, p4;
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
      p4_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= sq_vld[SQRT_STEPS];
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
      p4_vld <= p3_vld;
    end
  end

  logic [2*Q_W-1:0] m2, m3, m4;
  assign m2 = p1.x * p1.x;
  assign m3 = p2.xp * p2.xp;
  assign m4 = p3.xp * p3.x;

  pw_t p2_next, p3_next, p4_next;
  always_comb begin
    p2_next    = p1;
    p2_next.xp = m2[FRAC_BITS +: Q_W];
    p3_next    = p2;
    p3_next.xp = m3[FRAC_BITS +: Q_W];
    p4_next    = p3;
    p4_next.xp = m4[FRAC_BITS +: Q_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1.tir  <= sr[SQRT_STEPS].tir;
      p1.cpos <= cfin > 0;
      p1.x    <= xfull[Q_W-1:0];
      p1.xp   <= '0;
      p1.r0   <= sr[SQRT_STEPS].sz ? '0 : rqsq[FRAC_BITS +: Q_W];
      p2      <= p2_next;
      p3      <= p3_next;
      p4      <= p4_next;
    end
  end

  // output stage: r0 + (1 - r0) x^5, saturated; one on TIR or non-positive cosine
  logic [2*Q_W-1:0] tm;
  logic [Q_W:0]     sum;
  logic [Q_W-1:0]   refl;
  always_comb begin
    tm  = (ONE_Q - p4.r0) * p4.xp;
    sum = {1'b0, p4.r0} + {1'b0, tm[FRAC_BITS +: Q_W]};
    if (p4.tir || !p4.cpos || sum > {1'b0, ONE_Q}) refl = ONE_Q;
    else refl = sum[Q_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= p4_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.reflectance      <= REFL_W'(refl);
      out_data.internal_reflect <= p4.tir;
    end
  end

endmodule
`default_nettype wire

[rtl/core/schlick_fresnel_reflectance.sv]
`default_nettype none
// throughput: one item per cycle; the whole pipeline holds while a result
//   waits at the output, and fills freely while the output stage is empty
// the refraction divider, the r0 divider and the square root each retire
//   one bit per stage, which sets the depth
// reset: synchronous, clears all valid bits; no other state
// ----------------------------------------------------------------------------
// schlick_fresnel_reflectance
// Schlick approximation of Fresnel reflectance with total internal reflection.
// ----------------------------------------------------------------------------
module schlick_fresnel_reflectance (
  input  logic      clk,
  input  logic      rst,
  sfr_hit_if.sink   hit,
  sfr_res_if.source res
);
  import sfr_pkg::*;

  logic  en;
  logic  out_vld;
  hit_t  in_data;
  res_t  out_data;

  assign en        = !out_vld || res.ready;
  assign hit.ready = en;

  always_comb begin
    in_data.eye_x      = hit.eye_x;
    in_data.eye_y      = hit.eye_y;
    in_data.eye_z      = hit.eye_z;
    in_data.norm_x     = hit.norm_x;
    in_data.norm_y     = hit.norm_y;
    in_data.norm_z     = hit.norm_z;
    in_data.index_from = hit.index_from;
    in_data.index_to   = hit.index_to;
  end

  sfr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (hit.valid),
    .in_data  (in_data),
    .out_vld  (out_vld),
    .out_data (out_data)
  );

  assign res.valid            = out_vld;
  assign res.reflectance      = out_data.reflectance;
  assign res.internal_reflect = out_data.internal_reflect;

`ifndef SYNTHESIS
  a_tir_is_one: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_data.internal_reflect |-> out_data.reflectance == REFL_W'(ONE_Q))
    else $error("internal reflection without full reflectance");
  a_refl_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> out_data.reflectance <= REFL_W'(ONE_Q))
    else $error("reflectance above one");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_vld |-> hit.ready)
    else $error("input refused with empty output stage");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_data) && out_vld)
    else $error("result changed while stalled");
`endif

endmodule
`default_nettype wire

[tb/sfr_tb_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_tb_if
// Package of the testbench; the channel interfaces come from the RTL.
// ----------------------------------------------------------------------------
package sfr_tb_pkg;
  import sfr_pkg::*;

  localparam int MAX_WAIT = 5;
endpackage
`default_nettype wire

[tb/schlick_fresnel_reflectance_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// schlick_fresnel_reflectance_tb
// Drives hit items through the Schlick Fresnel block with random gaps and
// output stalls, and compares every reflectance item against a fixed-point
// prediction of the same arithmetic.
// ----------------------------------------------------------------------------
module schlick_fresnel_reflectance_tb;
  import sfr_pkg::*;
  import sfr_tb_pkg::*;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfr_hit_if hit ();
  sfr_res_if res ();

  schlick_fresnel_reflectance i_dut (
    .clk (clk),
    .rst (rst),
    .hit (hit.sink),
    .res (res.source)
  );

  always #10 clk = ~clk;

  res_t   expected_q[$];
  int     mismatches = 0;

  function automatic longint floor_q(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    r = 0;
    for (longint b = longint'(1) << 31; b != 0; b = b >> 1) begin
      if ((r + b) * (r + b) <= v) r = r + b;
    end
    return r;
  endfunction

  function automatic res_t fresnel_of(hit_t h);
    res_t   o;
    longint c, n1, n2, c2, sin2, d, s, r0, q, x, x2, x4, x5, refl;
    logic   tir;
    c  = floor_q(longint'(h.eye_x) * longint'(h.norm_x)
                 + longint'(h.eye_y) * longint'(h.norm_y)
                 + longint'(h.eye_z) * longint'(h.norm_z));
    if (c > ONE) c = ONE;
    if (c < -ONE) c = -ONE;
    n1  = longint'(h.index_from);
    n2  = longint'(h.index_to);
    tir = 1'b0;
    if (n1 > n2) begin
      if (n2 == 0) begin
        tir = 1'b1;
      end else begin
        c2   = (c * c) >> FRAC_BITS;
        sin2 = (n1 * n1 * (ONE - c2)) / (n2 * n2);
        if (sin2 > ONE) tir = 1'b1;
        else c = root_floor((ONE - sin2) << FRAC_BITS);
      end
    end
    if (tir || c <= 0) begin
      refl = ONE;
    end else begin
      d  = (n1 > n2) ? n1 - n2 : n2 - n1;
      s  = n1 + n2;
      r0 = 0;
      if (s != 0) begin
        q  = (d << FRAC_BITS) / s;
        r0 = (q * q) >> FRAC_BITS;
      end
      if (r0 > ONE) r0 = ONE;
      x    = ONE - c;
      x2   = (x * x) >> FRAC_BITS;
      x4   = (x2 * x2) >> FRAC_BITS;
      x5   = (x4 * x) >> FRAC_BITS;
      refl = r0 + (((ONE - r0) * x5) >> FRAC_BITS);
      if (refl > ONE) refl = ONE;
    end
    o.reflectance      = refl[REFL_W-1:0];
    o.internal_reflect = tir;
    return o;
  endfunction

  initial begin
    hit.valid      <= 1'b0;
    hit.eye_x      <= '0;
    hit.eye_y      <= '0;
    hit.eye_z      <= '0;
    hit.norm_x     <= '0;
    hit.norm_y     <= '0;
    hit.norm_z     <= '0;
    hit.index_from <= '0;
    hit.index_to   <= '0;
    res.ready      <= 1'b0;
  end

  // one item per call; valid drops only when the next item is not back to back
  task automatic send_hit(hit_t h);
    int gap;
    gap = $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      hit.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit.valid      <= 1'b1;
    hit.eye_x      <= h.eye_x;
    hit.eye_y      <= h.eye_y;
    hit.eye_z      <= h.eye_z;
    hit.norm_x     <= h.norm_x;
    hit.norm_y     <= h.norm_y;
    hit.norm_z     <= h.norm_z;
    hit.index_from <= h.index_from;
    hit.index_to   <= h.index_to;
    do @(posedge clk); while (!hit.ready);
    expected_q.push_back(fresnel_of(h));
  endtask

  // output side: random wait per item, then ready until the item is taken
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = $urandom_range(0, MAX_WAIT);
      if (w != 0) begin
        res.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && res.valid && res.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reflectance item %0d", res.reflectance);
      end else begin
        exp_r = expected_q.pop_front();
        if (res.reflectance !== exp_r.reflectance ||
            res.internal_reflect !== exp_r.internal_reflect) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected refl %0d tir %0b, got refl %0d tir %0b",
                     exp_r.reflectance, exp_r.internal_reflect,
                     res.reflectance, res.internal_reflect);
        end
      end
    end
  end

  function automatic hit_t hit_of(int ex, int ey, int ez, int nx, int ny, int nz,
                                  int n1, int n2);
    hit_t h;
    h.eye_x = 16'(ex); h.eye_y = 16'(ey); h.eye_z = 16'(ez);
    h.norm_x = 16'(nx); h.norm_y = 16'(ny); h.norm_z = 16'(nz);
    h.index_from = 16'(n1); h.index_to = 16'(n2);
    return h;
  endfunction

  // random unit-ish eye vector at a random angle to an axis-aligned normal
  function automatic hit_t random_hit();
    hit_t h;
    int   c, s;
    c = $urandom_range(0, 16384);
    s = int'($sqrt(real'(16384 * 16384 - c * c)));
    h.norm_x = 16'sd0; h.norm_y = 16'sd0; h.norm_z = 16'sd16384;
    h.eye_x  = $urandom_range(0, 1) ? 16'(s) : 16'(-s);
    h.eye_y  = 16'(int'($urandom_range(0, 300)) - 150);
    h.eye_z  = $urandom_range(0, 7) == 0 ? 16'(-c) : 16'(c);
    if ($urandom_range(0, 1)) begin
      // swap roles of axes so the normal lies along x instead of z
      h = hit_of(int'(h.eye_z), int'(h.eye_x), int'(h.eye_y), 16384, 0, 0, 0, 0);
    end
    h.index_from = 16'($urandom_range(16384, 40000));
    h.index_to   = 16'($urandom_range(16384, 40000));
    if ($urandom_range(0, 9) == 0) begin
      h.eye_x = 16'($urandom); h.eye_y = 16'($urandom); h.eye_z = 16'($urandom);
      h.norm_x = 16'($urandom); h.norm_y = 16'($urandom); h.norm_z = 16'($urandom);
      h.index_from = 16'($urandom); h.index_to = 16'($urandom);
    end
    return h;
  endfunction

  task automatic test_extremes();
    send_hit(hit_of(16384, 0, 0, 16384, 0, 0, 16384, 16384));
    send_hit(hit_of(0, 16384, 0, 0, 16384, 0, 16384, 24576));
    send_hit(hit_of(0, 0, -16384, 0, 0, 16384, 24576, 16384));
    send_hit(hit_of(32767, 32767, 32767, 32767, 32767, 32767, 65535, 16384));
    send_hit(hit_of(-32768, -32768, -32768, 32767, 32767, 32767, 16384, 65535));
    send_hit(hit_of(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 65535));
    send_hit(hit_of(0, 0, 0, 0, 0, 0, 20000, 16384));
    send_hit(hit_of(0, 0, 0, 0, 0, 0, 0, 0));
    send_hit(hit_of(8192, 0, 0, 16384, 0, 0, 16384, 0));
    send_hit(hit_of(16384, 0, 0, 16384, 0, 0, 0, 0));
    send_hit(hit_of(16384, 0, 0, 16384, 0, 0, 65535, 0));
    send_hit(hit_of(1, 1, 1, 1, 1, 1, 1, 65535));
  endtask

  task automatic test_interface_angles();
    // near the critical angle on the dense side, grazing and normal incidence
    send_hit(hit_of(11585, 0, 0, 16384, 0, 0, 24576, 16384));
    send_hit(hit_of(10923, 0, 0, 16384, 0, 0, 24576, 16384));
    send_hit(hit_of(12000, 0, 0, 16384, 0, 0, 24576, 16384));
    send_hit(hit_of(100, 0, 0, 16384, 0, 0, 16384, 21790));
    send_hit(hit_of(16384, 0, 0, 16384, 0, 0, 21790, 16384));
    send_hit(hit_of(16384, 0, 0, 16384, 0, 0, 16384, 16385));
    send_hit(hit_of(-100, 0, 0, 16384, 0, 0, 16384, 21790));
  endtask

  task automatic test_random_hits();
    for (int i = 0; i < 1000; i++) send_hit(random_hit());
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_interface_angles();
    test_random_hits();
    hit.valid <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
rtl/core/sfr_pkg.sv
rtl/core/sfr_if.sv
rtl/core/sfr_datapath.sv
rtl/core/schlick_fresnel_reflectance.sv
tb/sfr_tb_if.sv
tb/schlick_fresnel_reflectance_tb.sv
